// File: src/lts_pkg.sv
`default_nettype none

package lts_pkg;

    localparam int NODE_W        = 5;
    localparam int CFG_W         = 6;
    localparam int MAX_NODES_DEF = 32;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SELF  = 2'd1,
        ST_RANGE = 2'd2,
        ST_CYCLE = 2'd3
    } t_status;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Register index, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_NODE_COUNT = '0;

    // Commands from the sequencer to the graph unit.
    typedef struct packed {
        logic start;
        logic wr;
        logic build;
        logic sort;
        logic clear;
    } t_gr_ctl;

    // Result of the ready-node search.
    typedef struct packed {
        logic  found;
        t_node pick;
    } t_gr_sts;

endpackage

`default_nettype wire

// File: src/lexicographic_topological_sort.sv
// An edge transaction does not stall the input. A finish transaction stalls the input while
// the block counts in-degrees (one matrix row per cycle), sorts (one node per cycle), then
// sends the nodes and the status transaction, which output stalls can hold up. After a load
// error, a finish skips the count and sort and sends only the status transaction.
// Synchronous active-low reset clears the matrix, in-degrees, error, node count and output.
`default_nettype none

module lexicographic_topological_sort #(
    parameter int MAX_NODES = lts_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_func,
    input  wire lts_pkg::t_node             i_producer_node,
    input  wire lts_pkg::t_node             i_consumer_node,
    // Output channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output lts_pkg::t_node                  o_node,
    output logic                            o_is_status,
    output logic [1:0]                      o_status,
    // Configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lts_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lts_pkg::DATA_W-1:0] pwdata,
    output logic [lts_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import lts_pkg::*;

    // The node fields and the state hold at most 32 nodes.
    localparam int NODES = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_SORT,
        S_EMIT,
        S_STATUS
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_node_count;
    t_status          r_err;
    t_status          r_final;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rd;
    t_node            r_order [NODES];

    logic             r_o_valid;
    t_node            r_o_node;
    logic             r_o_is_status;
    t_status          r_o_status;

    logic [CNT_W-1:0] eff_count;
    logic             in_acc;
    logic             out_free;
    logic             out_load;
    logic             cfg_wr;
    logic             out_of_range;
    t_gr_ctl          gr_ctl;
    t_gr_sts          gr_sts;

    // The node count saturates at the number of nodes the state can hold.
    assign eff_count = (r_node_count > CFG_W'(NODES)) ? CNT_W'(NODES)
                                                      : CNT_W'(r_node_count);

    // Edges are only taken while the sequencer is idle.
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    // The output register can take a new result when empty or being drained.
    assign out_free = !r_o_valid || !i_stall;
    // A node or the status transaction enters the output register this cycle.
    assign out_load = out_free && (((r_state == S_EMIT) && (r_rd != r_cnt)) ||
                                   (r_state == S_STATUS));

    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[ADDR_W-1:2] == REG_NODE_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_NODE_COUNT) ? DATA_W'(r_node_count)
                                                          : '0;

    // The edge is out of range if either node is outside the node count.
    assign out_of_range = (CFG_W'(i_producer_node) >= CFG_W'(eff_count)) ||
                          (CFG_W'(i_consumer_node) >= CFG_W'(eff_count));

    always_comb begin
        gr_ctl.start = in_acc && (i_func == FUNC_FINISH) && (r_err == ST_OK);
        gr_ctl.wr    = in_acc && (i_func == FUNC_ADD) && (r_err == ST_OK) &&
                       !out_of_range && (i_producer_node != i_consumer_node);
        gr_ctl.build = (r_state == S_BUILD) && (r_idx != eff_count);
        gr_ctl.sort  = (r_state == S_SORT) && (r_cnt != eff_count);
        // The matrix is wiped once the sort is over, or at once on a failed finish.
        gr_ctl.clear = ((r_state == S_SORT) &&
                        ((r_cnt == eff_count) || !gr_sts.found)) ||
                       (in_acc && (i_func == FUNC_FINISH) && (r_err != ST_OK));
    end

    lts_graph #(
        .NODES (NODES)
    ) u_graph (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (gr_ctl),
        .i_wr_prod   (i_producer_node),
        .i_wr_cons   (i_consumer_node),
        .i_build_idx (r_idx[IDX_W-1:0]),
        .i_count     (eff_count),
        .o_sts       (gr_sts)
    );

    // Sequencer: loading, in-degree count, sort, then delivery of the results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= '0;
            r_err        <= ST_OK;
            r_o_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_node_count <= pwdata[CFG_W-1:0];
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_func == FUNC_ADD) begin
                            // Only the first error of a run is kept.
                            if (r_err == ST_OK) begin
                                if (out_of_range) begin
                                    r_err <= ST_RANGE;
                                end else if (i_producer_node == i_consumer_node) begin
                                    r_err <= ST_SELF;
                                end
                            end
                        end else if (r_err != ST_OK) begin
                            r_final <= r_err;
                            r_err   <= ST_OK;
                            r_state <= S_STATUS;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_BUILD;
                        end
                    end
                end
                S_BUILD: begin
                    if (r_idx == eff_count) begin
                        r_cnt   <= '0;
                        r_state <= S_SORT;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_SORT: begin
                    if (r_cnt == eff_count) begin
                        r_rd    <= '0;
                        r_state <= S_EMIT;
                    end else if (!gr_sts.found) begin
                        // Nodes remain but none is free: the graph has a cycle,
                        // and the partial order is dropped.
                        r_final <= ST_CYCLE;
                        r_state <= S_STATUS;
                    end else begin
                        r_order[r_cnt[IDX_W-1:0]] <= gr_sts.pick;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (r_rd == r_cnt) begin
                        r_final <= ST_OK;
                        r_state <= S_STATUS;
                    end else if (out_free) begin
                        r_o_node      <= r_order[r_rd[IDX_W-1:0]];
                        r_o_is_status <= 1'b0;
                        r_o_status    <= ST_OK;
                        r_rd          <= r_rd + CNT_W'(1);
                    end
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_o_node      <= '0;
                        r_o_is_status <= 1'b1;
                        r_o_status    <= r_final;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_node      = r_o_node;
    assign o_is_status = r_o_is_status;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire

// File: src/lts_graph.sv
`default_nettype none

module lts_graph #(
    parameter int  NODES = 32,
    localparam int IDX_W = $clog2(NODES),
    localparam int CNT_W = $clog2(NODES + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lts_pkg::t_gr_ctl i_ctl,
    input  wire lts_pkg::t_node   i_wr_prod,
    input  wire lts_pkg::t_node   i_wr_cons,
    input  wire logic [IDX_W-1:0] i_build_idx,
    input  wire logic [CNT_W-1:0] i_count,
    output lts_pkg::t_gr_sts      o_sts
);
    import lts_pkg::*;

    localparam int DEG_W = $clog2(NODES);

    logic [NODES-1:0] r_mat [NODES];
    logic [DEG_W-1:0] r_deg [NODES];
    logic [NODES-1:0] r_done;

    logic [NODES-1:0] vmask;
    logic [NODES-1:0] ready;
    logic [NODES-1:0] onehot;
    logic [NODES-1:0] row_build;
    logic [NODES-1:0] row_sort;
    logic [IDX_W-1:0] pick_idx;

    always_comb begin
        row_sort = '0;
        pick_idx = '0;
        for (int j = 0; j < NODES; j++) begin
            vmask[j] = CNT_W'(j) < i_count;
            ready[j] = vmask[j] && !r_done[j] && (r_deg[j] == '0);
        end
        // Lowest set bit of the ready vector.
        onehot    = ready & (~ready + NODES'(1));
        row_build = r_mat[i_build_idx] & vmask;
        for (int j = 0; j < NODES; j++) begin
            if (onehot[j]) begin
                row_sort = row_sort | r_mat[j];
                pick_idx = pick_idx | IDX_W'(j);
            end
        end
        row_sort   = row_sort & vmask;
        o_sts.found = |ready;
        o_sts.pick  = t_node'(pick_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            for (int j = 0; j < NODES; j++) begin
                r_mat[j] <= '0;
                r_deg[j] <= '0;
            end
        end else begin
            if (i_ctl.clear) begin
                for (int j = 0; j < NODES; j++) begin
                    r_mat[j] <= '0;
                end
            end else if (i_ctl.wr) begin
                r_mat[i_wr_prod[IDX_W-1:0]][i_wr_cons[IDX_W-1:0]] <= 1'b1;
            end

            if (i_ctl.start) begin
                r_done <= '0;
                for (int j = 0; j < NODES; j++) begin
                    r_deg[j] <= '0;
                end
            end else if (i_ctl.build) begin
                for (int j = 0; j < NODES; j++) begin
                    if (row_build[j]) begin
                        r_deg[j] <= r_deg[j] + DEG_W'(1);
                    end
                end
            end else if (i_ctl.sort && o_sts.found) begin
                r_done <= r_done | onehot;
                for (int j = 0; j < NODES; j++) begin
                    if (row_sort[j] && (r_deg[j] != '0)) begin
                        r_deg[j] <= r_deg[j] - DEG_W'(1);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/lts_checker.sv
`default_nettype none

module lts_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire lts_pkg::t_node             o_node,
    input wire logic                       o_is_status,
    input wire logic [1:0]                 o_status
);
    import lts_pkg::*;

    // A stalled result transaction holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_node, o_is_status, o_status}))
        else $error("output transaction changed while stalled");

    // Node items always carry an ok status.
    a_node_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_status |-> o_status == ST_OK)
        else $error("node item with nonzero status");

    // The status item carries node zero.
    a_status_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_status |-> o_node == '0)
        else $error("status item with nonzero node");

    // Reset leaves no result pending and the input open.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

endmodule

bind lexicographic_topological_sort lts_checker u_lts_checker (.*);

`default_nettype wire
